/* sv/assert_macros.svh */
// Assertion macros used by the deframer top RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a boolean condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check an implication property at every rising clock edge outside reset.
`define ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/emd_pkg.sv */
// Constants and result type for the escaped marker deframer.
package emd_pkg;

    localparam logic [7:0] MARKER0       = 8'h7F;
    localparam logic [7:0] MARKER1       = 8'hFF;
    localparam logic [7:0] MARKER2       = 8'hFE;

    localparam logic [7:0] TAG_ESC       = 8'h00;
    localparam logic [7:0] TAG_CODED     = 8'h01;
    localparam logic [7:0] TAG_CODED_END = 8'h02;
    localparam logic [7:0] TAG_SKIP      = 8'h03;
    localparam logic [7:0] TAG_TABLE_LO  = 8'h04;
    localparam logic [7:0] TAG_TABLE_HI  = 8'h07;
    localparam logic [7:0] TAG_TABLE_END = 8'h08;
    localparam logic [7:0] TAG_DEFL      = 8'h09;
    localparam logic [7:0] TAG_DEFL_END  = 8'h0A;

    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;
    localparam logic [1:0] KIND_BROKEN   = 2'd3;

    localparam logic [1:0] FTYPE_DEFL    = 2'd0;
    localparam logic [1:0] FTYPE_CODED   = 2'd1;
    localparam logic [1:0] FTYPE_TABLE   = 2'd2;

    localparam int unsigned MAX_RES      = 4;
    localparam logic [2:0]  SKIP_LEN     = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  ftype;
        logic [1:0]  slot;
        logic [7:0]  pay;
        logic [31:0] len;
        logic        last;
    } t_res;

endpackage

/* sv/escaped_marker_deframer_top.sv */
// Escaped marker deframer: marker search, frame parsing and result buffer.
// Results of an item are registered and appear in the cycle after it is accepted.
// Throughput: one item per cycle while each item causes at most one result and the output
// is not stalled; an item with more results holds the input while the result buffer drains.
// Reset (synchronous, active low): hunting outside any frame, buffer empty.
`include "assert_macros.svh"

module escaped_marker_deframer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_event_kind,
    output logic [1:0] o_frame_type,
    output logic [1:0] o_table_slot,
    output logic [7:0] o_payload_byte,
    output logic [31:0] o_declared_length,
    output logic       o_last
);
    import emd_pkg::*;

    typedef enum logic [2:0] {
        M_HUNT  = 3'd0,
        M_SKIP  = 3'd1,
        M_LEN   = 3'd2,
        M_DEFL  = 3'd3,
        M_CODED = 3'd4,
        M_TABLE = 3'd5
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_mc, n_mc;
    logic [2:0]  r_sc, n_sc;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_slot, n_slot;
    logic [2:0]  r_cnt, n_cnt;
    t_res        r_res [MAX_RES];
    t_res        n_res [MAX_RES];

    logic        in_accept;
    logic        out_take;
    logic        do_open;
    logic        in_fr;
    logic [1:0]  nn;

    function automatic t_res mk_ev(t_mode m, logic [1:0] slot, logic [31:0] acc,
                                   logic [1:0] kind, logic [7:0] pay);
        t_res e;
        e       = '0;
        e.kind  = kind;
        e.pay   = (kind == KIND_PAYLOAD) ? pay : 8'h00;
        case (m)
            M_DEFL: begin
                e.ftype = FTYPE_DEFL;
                e.len   = acc;
            end
            M_CODED: begin
                e.ftype = FTYPE_CODED;
            end
            default: begin
                e.ftype = FTYPE_TABLE;
                e.slot  = slot;
            end
        endcase
        return e;
    endfunction

    function automatic logic is_frame(t_mode m);
        return (m == M_DEFL) || (m == M_CODED) || (m == M_TABLE);
    endfunction

    assign out_take    = (r_cnt != 3'd0) && !i_out_stall;
    assign o_in_stall  = (r_cnt > 3'd1) || ((r_cnt == 3'd1) && i_out_stall);
    assign in_accept   = i_in_valid && !o_in_stall;

    assign o_out_valid       = (r_cnt != 3'd0);
    assign o_event_kind      = r_res[0].kind;
    assign o_frame_type      = r_res[0].ftype;
    assign o_table_slot      = r_res[0].slot;
    assign o_payload_byte    = r_res[0].pay;
    assign o_declared_length = r_res[0].len;
    assign o_last            = r_res[0].last;

    always_comb begin
        n_mode  = r_mode;
        n_mc    = r_mc;
        n_sc    = r_sc;
        n_acc   = r_acc;
        n_slot  = r_slot;
        n_cnt   = 3'd0;
        n_res   = '{default: '0};
        do_open = 1'b0;
        in_fr   = 1'b0;
        nn      = r_sc[1:0];

        if (r_mode == M_SKIP) begin
            if (r_sc <= 3'd1) begin
                n_sc   = 3'd0;
                n_mode = M_HUNT;
            end else begin
                n_sc = 3'(r_sc - 3'd1);
            end
            n_mc = 2'd0;
        end else if (r_mode == M_LEN) begin
            n_acc = r_acc | ({24'h0, i_rx_byte} << {nn, 3'b000});
            if (nn == 2'd3) begin
                n_sc   = 3'd0;
                n_mc   = 2'd0;
                n_mode = M_DEFL;
                n_res[n_cnt[1:0]] = mk_ev(n_mode, n_slot, n_acc, KIND_START, 8'h00);
                n_cnt  = 3'(n_cnt + 3'd1);
            end else begin
                n_sc = {1'b0, 2'(nn + 2'd1)};
            end
        end else begin
            if (!is_frame(r_mode)) begin
                n_mode = M_HUNT;
            end
            in_fr = is_frame(n_mode);
            if (r_mc == 2'd3) begin
                n_mc = 2'd0;
                if (!in_fr) begin
                    do_open = (i_rx_byte != TAG_ESC);
                end else if (i_rx_byte == TAG_ESC) begin
                    n_res[0] = mk_ev(n_mode, n_slot, n_acc, KIND_PAYLOAD, MARKER0);
                    n_res[1] = mk_ev(n_mode, n_slot, n_acc, KIND_PAYLOAD, MARKER1);
                    n_res[2] = mk_ev(n_mode, n_slot, n_acc, KIND_PAYLOAD, MARKER2);
                    n_cnt    = 3'd3;
                    if (n_mode != M_DEFL) begin
                        n_res[3] = mk_ev(n_mode, n_slot, n_acc, KIND_PAYLOAD, TAG_ESC);
                        n_cnt    = 3'd4;
                    end
                end else if (n_mode == M_DEFL && i_rx_byte == TAG_DEFL_END) begin
                    n_res[0] = mk_ev(n_mode, n_slot, n_acc, KIND_END, 8'h00);
                    n_cnt    = 3'd1;
                    n_mode   = M_SKIP;
                    n_sc     = SKIP_LEN;
                end else if (n_mode == M_CODED && i_rx_byte == TAG_CODED_END) begin
                    n_res[0] = mk_ev(n_mode, n_slot, n_acc, KIND_END, 8'h00);
                    n_cnt    = 3'd1;
                    n_mode   = M_HUNT;
                end else if (n_mode == M_TABLE && i_rx_byte == TAG_TABLE_END) begin
                    n_res[0] = mk_ev(n_mode, n_slot, n_acc, KIND_END, 8'h00);
                    n_cnt    = 3'd1;
                    n_mode   = M_HUNT;
                end else if (n_mode == M_TABLE && (i_rx_byte == TAG_CODED ||
                             i_rx_byte inside {[TAG_TABLE_LO:TAG_TABLE_HI]})) begin
                    n_res[0] = mk_ev(n_mode, n_slot, n_acc, KIND_END, 8'h00);
                    n_cnt    = 3'd1;
                    do_open  = 1'b1;
                end else begin
                    n_res[0] = mk_ev(n_mode, n_slot, n_acc, KIND_BROKEN, 8'h00);
                    n_cnt    = 3'd1;
                    do_open  = 1'b1;
                end
            end else if (i_rx_byte == ((r_mc == 2'd0) ? MARKER0 :
                                       (r_mc == 2'd1) ? MARKER1 : MARKER2)) begin
                n_mc = 2'(r_mc + 2'd1);
            end else begin
                if (in_fr && r_mc != 2'd0) begin
                    n_res[n_cnt[1:0]] = mk_ev(n_mode, n_slot, n_acc, KIND_PAYLOAD, MARKER0);
                    n_cnt = 3'(n_cnt + 3'd1);
                end
                if (in_fr && r_mc == 2'd2) begin
                    n_res[n_cnt[1:0]] = mk_ev(n_mode, n_slot, n_acc, KIND_PAYLOAD, MARKER1);
                    n_cnt = 3'(n_cnt + 3'd1);
                end
                if (i_rx_byte == MARKER0) begin
                    n_mc = 2'd1;
                end else begin
                    n_mc = 2'd0;
                    if (in_fr) begin
                        n_res[n_cnt[1:0]] = mk_ev(n_mode, n_slot, n_acc, KIND_PAYLOAD,
                                                  i_rx_byte);
                        n_cnt = 3'(n_cnt + 3'd1);
                    end
                end
            end

            if (do_open) begin
                n_sc = 3'd0;
                case (i_rx_byte)
                    TAG_SKIP: begin
                        n_mode = M_SKIP;
                        n_sc   = SKIP_LEN;
                    end
                    TAG_DEFL: begin
                        n_mode = M_LEN;
                        n_acc  = 32'h0;
                    end
                    TAG_CODED: begin
                        n_mode = M_CODED;
                        n_res[n_cnt[1:0]] = mk_ev(n_mode, n_slot, n_acc, KIND_START, 8'h00);
                        n_cnt  = 3'(n_cnt + 3'd1);
                    end
                    default: begin
                        if (i_rx_byte inside {[TAG_TABLE_LO:TAG_TABLE_HI]}) begin
                            n_mode = M_TABLE;
                            n_slot = i_rx_byte[1:0];
                            n_res[n_cnt[1:0]] = mk_ev(n_mode, n_slot, n_acc, KIND_START,
                                                      8'h00);
                            n_cnt  = 3'(n_cnt + 3'd1);
                        end else begin
                            n_mode = M_HUNT;
                        end
                    end
                endcase
            end
        end

        if (n_cnt != 3'd0) begin
            n_res[2'(n_cnt - 3'd1)].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_HUNT;
            r_mc   <= 2'd0;
            r_sc   <= 3'd0;
            r_acc  <= 32'h0;
            r_slot <= 2'd0;
            r_cnt  <= 3'd0;
        end else if (in_accept) begin
            r_mode <= n_mode;
            r_mc   <= n_mc;
            r_sc   <= n_sc;
            r_acc  <= n_acc;
            r_slot <= n_slot;
            r_cnt  <= n_cnt;
        end else if (out_take) begin
            r_cnt <= 3'(r_cnt - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= n_res;
        end else if (out_take) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
            r_res[2] <= r_res[3];
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, r_cnt <= 3'd4, "result count out of range")
    `ASSERT_IMPLY(a_accept_drained, in_accept, (r_cnt == 3'd0) || ((r_cnt == 3'd1) && out_take), "item accepted over pending results")
    `ASSERT_IMPLY(a_last_on_final, o_out_valid, o_last == (r_cnt == 3'd1), "last flag not on final buffered result")
    `ASSERT_IMPLY(a_slot_table_only, o_out_valid && o_frame_type != FTYPE_TABLE, o_table_slot == 2'd0, "table slot on non-table frame")
    `ASSERT_IMPLY(a_len_defl_only, o_out_valid && o_frame_type != FTYPE_DEFL, o_declared_length == 32'h0, "length on non-deflated frame")

endmodule

/* test/escaped_marker_deframer_checker.sv */
// Predictor and result checker for the escaped marker deframer channels.
module escaped_marker_deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_event_kind,
    input  logic [1:0]  i_frame_type,
    input  logic [1:0]  i_table_slot,
    input  logic [7:0]  i_payload_byte,
    input  logic [31:0] i_declared_length,
    input  logic        i_last,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import emd_pkg::*;

    typedef enum logic [2:0] {
        M_HUNT,
        M_SKIP,
        M_LEN,
        M_DEFL,
        M_CODED,
        M_TABLE
    } t_mode;

    t_mode       mode = M_HUNT;
    logic [1:0]  match_cnt = 2'd0;
    logic [2:0]  skip_cnt = 3'd0;
    logic [31:0] len_acc = 32'd0;
    logic [1:0]  cur_slot = 2'd0;

    t_res        step_events[$];
    t_res        predicted_events[$];
    t_res        seen;
    t_res        want;
    t_res        entry;
    int unsigned fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = predicted_events.size();

    function automatic logic [7:0] marker_at(logic [1:0] idx);
        case (idx)
            2'd0:    return MARKER0;
            2'd1:    return MARKER1;
            default: return MARKER2;
        endcase
    endfunction

    function automatic bit in_frame();
        return mode == M_DEFL || mode == M_CODED || mode == M_TABLE;
    endfunction

    function automatic bit is_table_tag(logic [7:0] tag);
        return tag >= TAG_TABLE_LO && tag <= TAG_TABLE_HI;
    endfunction

    function automatic void push_event(logic [1:0] kind, logic [7:0] pay);
        t_res r;
        r.kind = kind;
        r.pay  = (kind == KIND_PAYLOAD) ? pay : 8'h00;
        r.last = 1'b0;
        case (mode)
            M_DEFL: begin
                r.ftype = FTYPE_DEFL;
                r.slot  = 2'd0;
                r.len   = len_acc;
            end
            M_CODED: begin
                r.ftype = FTYPE_CODED;
                r.slot  = 2'd0;
                r.len   = 32'd0;
            end
            default: begin
                r.ftype = FTYPE_TABLE;
                r.slot  = cur_slot;
                r.len   = 32'd0;
            end
        endcase
        if (step_events.size() < MAX_RES) step_events.push_back(r);
    endfunction

    function automatic void open_frame(logic [7:0] tag);
        skip_cnt = 3'd0;
        if (tag == TAG_SKIP) begin
            mode     = M_SKIP;
            skip_cnt = SKIP_LEN;
        end else if (tag == TAG_DEFL) begin
            mode    = M_LEN;
            len_acc = 32'd0;
        end else if (tag == TAG_CODED) begin
            mode = M_CODED;
            push_event(KIND_START, 8'h00);
        end else if (is_table_tag(tag)) begin
            mode     = M_TABLE;
            cur_slot = 2'(tag - TAG_TABLE_LO);
            push_event(KIND_START, 8'h00);
        end else begin
            mode = M_HUNT;
        end
    endfunction

    function automatic void take_tag(logic [7:0] tag);
        if (!in_frame()) begin
            if (tag != TAG_ESC) open_frame(tag);
            return;
        end
        if (tag == TAG_ESC) begin
            push_event(KIND_PAYLOAD, MARKER0);
            push_event(KIND_PAYLOAD, MARKER1);
            push_event(KIND_PAYLOAD, MARKER2);
            if (mode != M_DEFL) push_event(KIND_PAYLOAD, TAG_ESC);
            return;
        end
        case (mode)
            M_DEFL: begin
                if (tag == TAG_DEFL_END) begin
                    push_event(KIND_END, 8'h00);
                    mode     = M_SKIP;
                    skip_cnt = SKIP_LEN;
                    return;
                end
            end
            M_CODED: begin
                if (tag == TAG_CODED_END) begin
                    push_event(KIND_END, 8'h00);
                    mode = M_HUNT;
                    return;
                end
            end
            default: begin
                if (tag == TAG_TABLE_END) begin
                    push_event(KIND_END, 8'h00);
                    mode = M_HUNT;
                    return;
                end
                if (tag == TAG_CODED || is_table_tag(tag)) begin
                    push_event(KIND_END, 8'h00);
                    open_frame(tag);
                    return;
                end
            end
        endcase
        push_event(KIND_BROKEN, 8'h00);
        open_frame(tag);
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        logic [1:0] n;
        bit         framed;
        step_events.delete();
        if (mode == M_SKIP) begin
            if (skip_cnt <= 3'd1) begin
                skip_cnt = 3'd0;
                mode     = M_HUNT;
            end else begin
                skip_cnt = skip_cnt - 3'd1;
            end
            match_cnt = 2'd0;
        end else if (mode == M_LEN) begin
            n       = skip_cnt[1:0];
            len_acc = len_acc | ({24'h0, b} << (8 * n));
            if (n == 2'd3) begin
                skip_cnt  = 3'd0;
                match_cnt = 2'd0;
                mode      = M_DEFL;
                push_event(KIND_START, 8'h00);
            end else begin
                skip_cnt = {1'b0, n} + 3'd1;
            end
        end else if (match_cnt == 2'd3) begin
            match_cnt = 2'd0;
            take_tag(b);
        end else if (b == marker_at(match_cnt)) begin
            match_cnt = match_cnt + 2'd1;
        end else begin
            framed = in_frame();
            if (framed) begin
                for (int i = 0; i < match_cnt; i++) push_event(KIND_PAYLOAD, marker_at(2'(i)));
            end
            if (b == MARKER0) begin
                match_cnt = 2'd1;
            end else begin
                match_cnt = 2'd0;
                if (framed) push_event(KIND_PAYLOAD, b);
            end
        end
    endfunction

    function automatic void note_failure(string what, t_res exp_r, t_res act_r);
        if (fail_count < 10) begin
            $display("%0t %s: expected kind %0d type %0d slot %0d byte %h len %h last %0d,",
                     $realtime, what,
                     exp_r.kind, exp_r.ftype, exp_r.slot, exp_r.pay, exp_r.len, exp_r.last,
                     " got kind %0d type %0d slot %0d byte %h len %h last %0d",
                     act_r.kind, act_r.ftype, act_r.slot, act_r.pay, act_r.len, act_r.last);
        end
        fail_count++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode      = M_HUNT;
            match_cnt = 2'd0;
            skip_cnt  = 3'd0;
            len_acc   = 32'd0;
            cur_slot  = 2'd0;
            predicted_events.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_rx_byte);
                foreach (step_events[k]) begin
                    entry      = step_events[k];
                    entry.last = (k == step_events.size() - 1);
                    predicted_events.push_back(entry);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                seen = {i_event_kind, i_frame_type, i_table_slot, i_payload_byte,
                        i_declared_length, i_last};
                if (predicted_events.size() == 0) begin
                    note_failure("unexpected item", '0, seen);
                end else begin
                    want = predicted_events.pop_front();
                    if (seen.kind !== want.kind || seen.ftype !== want.ftype ||
                        seen.slot !== want.slot || seen.pay !== want.pay ||
                        seen.len !== want.len || seen.last !== want.last) begin
                        note_failure("mismatch", want, seen);
                    end
                end
            end
        end
    end

endmodule

/* test/escaped_marker_deframer_top_tb.sv */
// Testbench top: byte stream stimulus, output stalls and verdict for the deframer.
module escaped_marker_deframer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import emd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned STREAM_LEN  = 400;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_stall = 1'b0;
    logic        steady = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  event_kind;
    logic [1:0]  frame_type;
    logic [1:0]  table_slot;
    logic [7:0]  payload_byte;
    logic [31:0] declared_length;
    logic        last;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycles = 0;

    logic [7:0]  byte_stream[$];

    escaped_marker_deframer_top u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_rx_byte         (rx_byte),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_event_kind      (event_kind),
        .o_frame_type      (frame_type),
        .o_table_slot      (table_slot),
        .o_payload_byte    (payload_byte),
        .o_declared_length (declared_length),
        .o_last            (last)
    );

    escaped_marker_deframer_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_rx_byte         (rx_byte),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_event_kind      (event_kind),
        .i_frame_type      (frame_type),
        .i_table_slot      (table_slot),
        .i_payload_byte    (payload_byte),
        .i_declared_length (declared_length),
        .i_last            (last),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 16);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void put_marker(logic [7:0] tag);
        byte_stream.push_back(MARKER0);
        byte_stream.push_back(MARKER1);
        byte_stream.push_back(MARKER2);
        byte_stream.push_back(tag);
    endfunction

    function automatic void put_word(logic [31:0] w);
        for (int i = 0; i < 4; i++) byte_stream.push_back(w[8 * i +: 8]);
    endfunction

    function automatic logic [7:0] stray_tag();
        return 8'($urandom_range(15));
    endfunction

    function automatic logic [31:0] raw_word();
        if ($urandom_range(3) == 0) return {TAG_CODED, MARKER2, MARKER1, MARKER0};
        return $urandom;
    endfunction

    function automatic void put_body();
        int unsigned n;
        n = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
        repeat (n) begin
            case ($urandom_range(39))
                0, 1, 2: put_marker(TAG_ESC);
                3: byte_stream.push_back(MARKER0);
                4: begin
                    byte_stream.push_back(MARKER0);
                    byte_stream.push_back(MARKER1);
                end
                5: put_marker(stray_tag());
                default: byte_stream.push_back(8'($urandom_range(255)));
            endcase
        end
    endfunction

    function automatic void put_random_sequence();
        int unsigned pick;
        int unsigned r;
        logic [7:0]  alt;
        pick = $urandom_range(99);
        r    = $urandom_range(9);
        if (pick < 25) begin
            put_marker(TAG_CODED);
            put_body();
            put_marker(r < 9 ? TAG_CODED_END : stray_tag());
        end else if (pick < 50) begin
            put_marker(TAG_TABLE_LO + 8'($urandom_range(3)));
            put_body();
            if (r < 5) begin
                put_marker(TAG_TABLE_END);
            end else if (r < 9) begin
                alt = ($urandom_range(4) == 0) ? TAG_CODED
                                              : TAG_TABLE_LO + 8'($urandom_range(3));
                put_marker(alt);
                put_body();
                put_marker(alt == TAG_CODED ? TAG_CODED_END : TAG_TABLE_END);
            end else begin
                put_marker(stray_tag());
            end
        end else if (pick < 75) begin
            put_marker(TAG_DEFL);
            case ($urandom_range(3))
                0:       put_word(32'h0000_0000);
                1:       put_word(32'hFFFF_FFFF);
                default: put_word($urandom);
            endcase
            put_body();
            put_marker(r < 9 ? TAG_DEFL_END : stray_tag());
            put_word(raw_word());
        end else if (pick < 85) begin
            put_marker(TAG_SKIP);
            put_word(raw_word());
        end else begin
            case (r)
                0, 1, 2: repeat ($urandom_range(1, 4))
                    byte_stream.push_back(8'($urandom_range(255)));
                3, 4: put_marker(8'($urandom_range(TAG_DEFL_END + 1, 255)));
                5: put_marker(TAG_ESC);
                6: put_marker(TAG_CODED_END);
                7: put_marker(TAG_TABLE_END);
                8: put_marker(TAG_DEFL_END);
                default: begin
                    byte_stream.push_back(MARKER0);
                    byte_stream.push_back(MARKER1);
                    byte_stream.push_back(8'($urandom_range(255)));
                end
            endcase
        end
    endfunction

    initial begin
        bit calm;

        put_marker(TAG_CODED);
        byte_stream.push_back(8'h00);
        byte_stream.push_back(8'hFF);
        byte_stream.push_back(MARKER0);
        byte_stream.push_back(MARKER1);
        byte_stream.push_back(MARKER0);
        byte_stream.push_back(MARKER1);
        byte_stream.push_back(MARKER2);
        byte_stream.push_back(TAG_ESC);
        put_marker(TAG_TABLE_LO + 8'd1);
        put_marker(TAG_TABLE_HI);
        put_marker(TAG_TABLE_END);
        while (byte_stream.size() < STREAM_LEN) put_random_sequence();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (byte_stream[idx]) begin
            calm = (idx >= 150 && idx < 260);
            steady <= calm;
            while (!calm && $urandom_range(99) < 16) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte  <= byte_stream[idx];
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
        in_valid <= 1'b0;
        steady   <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
